// ===== rtl/lfga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-free gate allocator package
// Shared sizes, command codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package lfga_pkg;

	localparam int MAX_GATES    = 64;
	localparam int COUNT_BITS   = 16;
	localparam int GATE_W       = $clog2(MAX_GATES);
	localparam int CNT_W        = $clog2(MAX_GATES + 2);
	localparam int SUM_W        = COUNT_BITS + 1;

	// fixed field widths
	localparam int CMD_W        = 2;
	localparam int TIME_W       = 32;
	localparam int GATE_TOTAL_W = 7;
	localparam int GATE_NUM_W   = 7;
	localparam int BEST_W       = 17;
	localparam int BEST_MAX     = 131071;

	localparam logic [CMD_W-1:0] CMD_BOOK_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOOK_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ALLOC,
		S_INC,
		S_SUM,
		S_MAX,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_item;
		logic check;
		logic alloc;
		logic inc;
		logic sum_step;
		logic max_step;
		logic finish;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             order_err;
		logic             none_free;
		logic             sum_done;
		logic             max_done;
		logic             out_free;
	} dp_status_t;

endpackage

// ===== rtl/lfga_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-free gate allocator channels
// Valid/ready channels for booking words and result words.
// ----------------------------------------------------------------------------
interface lfga_item_if;
	logic                          valid;
	logic                          ready;
	logic [lfga_pkg::CMD_W-1:0]    command;
	logic [lfga_pkg::TIME_W-1:0]   arrive_time;
	logic [lfga_pkg::TIME_W-1:0]   depart_time;

	modport source (output valid, output command, output arrive_time, output depart_time,
		input ready);
	modport sink (input valid, input command, input arrive_time, input depart_time,
		output ready);
endinterface

interface lfga_result_if;
	logic                            valid;
	logic                            ready;
	logic [lfga_pkg::GATE_NUM_W-1:0] gate_index;
	logic                            served;
	logic                            order_error;
	logic [lfga_pkg::BEST_W-1:0]     best_total;
	logic                            report_valid;

	modport source (output valid, output gate_index, output served, output order_error,
		output best_total, output report_valid, input ready);
	modport sink (input valid, input gate_index, input served, input order_error,
		input best_total, input report_valid, output ready);
endinterface

// ===== rtl/lfga_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfga_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lfga_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-free gate allocator controller
// Sequences booking and finish words through the datapath.
// ----------------------------------------------------------------------------
module lfga_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lfga_pkg::dp_status_t status,
	output lfga_pkg::ctrl_cmd_t  cmd
);

	lfga_pkg::state_t state_q;
	lfga_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfga_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		state_next = state_q;
		case (state_q)
			lfga_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_next    = lfga_pkg::S_CHECK;
				end
			end
			lfga_pkg::S_CHECK: begin
				case (status.command)
					lfga_pkg::CMD_BOOK_A, lfga_pkg::CMD_BOOK_B: begin
						cmd.check  = 1'b1;
						state_next = status.order_err ? lfga_pkg::S_RESP : lfga_pkg::S_ALLOC;
					end
					lfga_pkg::CMD_FINISH: begin
						state_next = lfga_pkg::S_SUM;
					end
					default: begin
						state_next = lfga_pkg::S_RESP;
					end
				endcase
			end
			lfga_pkg::S_ALLOC: begin
				cmd.alloc  = 1'b1;
				state_next = status.none_free ? lfga_pkg::S_RESP : lfga_pkg::S_INC;
			end
			lfga_pkg::S_INC: begin
				cmd.inc    = 1'b1;
				state_next = lfga_pkg::S_RESP;
			end
			lfga_pkg::S_SUM: begin
				cmd.sum_step = 1'b1;
				if (status.sum_done) begin
					state_next = lfga_pkg::S_MAX;
				end
			end
			lfga_pkg::S_MAX: begin
				cmd.max_step = 1'b1;
				if (status.max_done) begin
					cmd.finish = 1'b1;
					state_next = lfga_pkg::S_RESP;
				end
			end
			lfga_pkg::S_RESP: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.load_item = 1'b1;
						state_next    = lfga_pkg::S_CHECK;
					end else begin
						state_next = lfga_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_next = lfga_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lfga_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-free gate allocator datapath
// Gate bitmaps, departure registers, use-count RAMs, finish sweep, result regs.
// ----------------------------------------------------------------------------
module lfga_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfga_pkg::GATE_TOTAL_W-1:0]   cfg_data,
	input  logic [lfga_pkg::CMD_W-1:0]          in_command,
	input  logic [lfga_pkg::TIME_W-1:0]         in_arrive,
	input  logic [lfga_pkg::TIME_W-1:0]         in_depart,
	input  lfga_pkg::ctrl_cmd_t                 cmd,
	output lfga_pkg::dp_status_t                status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [lfga_pkg::GATE_NUM_W-1:0]     out_gate,
	output logic                                out_served,
	output logic                                out_err,
	output logic [lfga_pkg::BEST_W-1:0]         out_best,
	output logic                                out_report
);

	localparam int NG = lfga_pkg::MAX_GATES;
	localparam int GW = lfga_pkg::GATE_W;
	localparam int CW = lfga_pkg::CNT_W;
	localparam int UW = lfga_pkg::COUNT_BITS;
	localparam int SW = lfga_pkg::SUM_W;
	localparam int TW = lfga_pkg::TIME_W;

	function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] a, input logic [UW-1:0] b);
		logic [UW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[UW] ? {UW{1'b1}} : s[UW-1:0];
	endfunction

	// configuration and current word
	logic [lfga_pkg::GATE_TOTAL_W-1:0] gate_total_q;
	logic [lfga_pkg::CMD_W-1:0]        cmd_q;
	logic [TW-1:0]                     arrive_q;
	logic [TW-1:0]                     depart_q;

	// per-class gate state
	logic [NG-1:0] busy_a_q, busy_b_q;
	logic [NG-1:0] val_a_q, val_b_q;
	logic [TW-1:0] rel_a_q [NG];
	logic [TW-1:0] rel_b_q [NG];
	logic [TW-1:0] last_a_q, last_b_q;

	// allocation and sweep
	logic [GW-1:0] gate_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [GW-1:0] pend_addr_q;
	logic          za_q, zb_q;
	logic [UW-1:0] sa_q, sb_q;
	logic [SW-1:0] best_q;

	// result held for the output register
	logic [lfga_pkg::GATE_NUM_W-1:0] res_gate_q;
	logic                            res_served_q;
	logic                            res_err_q;
	logic [lfga_pkg::BEST_W-1:0]     res_best_q;
	logic                            res_report_q;

	logic          cls;
	logic [CW-1:0] n_act;
	logic [NG-1:0] busy_sel, lim, free_m, onehot, expired;
	logic [GW-1:0] alloc_idx;
	logic          order_err;
	logic          none_free;
	logic          issue_sum, issue_max;
	logic [CW-1:0] am1, bm1;

	logic          we_a, we_b;
	logic [GW-1:0] waddr, raddr_a, raddr_b;
	logic [UW-1:0] wdata_a, wdata_b, rd_a, rd_b;
	logic [UW-1:0] pre_a, pre_b, rd_sel, inc_val;
	logic          v_sel;
	logic [SW-1:0] tsum;

	assign cls   = cmd_q[0];
	assign n_act = (32'(gate_total_q) > 32'(NG)) ? CW'(NG) : CW'(gate_total_q);

	assign order_err = cls ? (arrive_q < last_b_q) : (arrive_q < last_a_q);
	assign busy_sel  = cls ? busy_b_q : busy_a_q;

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			expired[g] = cls ? (rel_b_q[g] < arrive_q) : (rel_a_q[g] < arrive_q);
			lim[g]     = CW'(g) < n_act;
		end
	end

	// lowest free gate: isolate lowest set bit, then encode
	assign free_m    = ~busy_sel & lim;
	assign onehot    = free_m & (~free_m + NG'(1));
	assign none_free = (free_m == '0);

	always_comb begin
		alloc_idx = '0;
		for (int g = 0; g < NG; g++) begin
			alloc_idx = alloc_idx | (GW'(g) & {GW{onehot[g]}});
		end
	end

	assign issue_sum = cnt_q < n_act;
	assign issue_max = cnt_q <= n_act;
	assign am1       = cnt_q - CW'(1);
	assign bm1       = n_act - cnt_q - CW'(1);

	always_comb begin
		raddr_a = cnt_q[GW-1:0];
		raddr_b = cnt_q[GW-1:0];
		if (cmd.alloc) begin
			raddr_a = alloc_idx;
			raddr_b = alloc_idx;
		end else if (cmd.max_step) begin
			raddr_a = am1[GW-1:0];
			raddr_b = bm1[GW-1:0];
		end
	end

	assign rd_sel  = cls ? rd_b : rd_a;
	assign v_sel   = cls ? val_b_q[gate_q] : val_a_q[gate_q];
	assign inc_val = !v_sel ? UW'(1) : sat_add(rd_sel, UW'(1));

	assign pre_a = sat_add(sa_q, val_a_q[pend_addr_q] ? rd_a : '0);
	assign pre_b = sat_add(sb_q, val_b_q[pend_addr_q] ? rd_b : '0);

	assign tsum = (za_q ? '0 : SW'(rd_a)) + (zb_q ? '0 : SW'(rd_b));

	// prefix sums overwrite the counts in place
	always_comb begin
		we_a    = 1'b0;
		we_b    = 1'b0;
		waddr   = gate_q;
		wdata_a = inc_val;
		wdata_b = inc_val;
		if (cmd.inc) begin
			we_a = !cls;
			we_b = cls;
		end else if (cmd.sum_step && pend_q) begin
			we_a    = 1'b1;
			we_b    = 1'b1;
			waddr   = pend_addr_q;
			wdata_a = pre_a;
			wdata_b = pre_b;
		end
	end

	lfga_ram #(.WIDTH(UW), .DEPTH(NG)) u_uses_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata_a),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	lfga_ram #(.WIDTH(UW), .DEPTH(NG)) u_uses_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata_b),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_total_q <= '0;
			busy_a_q     <= '0;
			busy_b_q     <= '0;
			val_a_q      <= '0;
			val_b_q      <= '0;
			last_a_q     <= '0;
			last_b_q     <= '0;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				gate_total_q <= cfg_data;
			end
			if (cmd.load_item) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end
			if (cmd.check && !order_err) begin
				if (cls) begin
					last_b_q <= arrive_q;
					busy_b_q <= busy_b_q & ~expired;
				end else begin
					last_a_q <= arrive_q;
					busy_a_q <= busy_a_q & ~expired;
				end
			end
			if (cmd.alloc && !none_free) begin
				if (cls) begin
					busy_b_q[alloc_idx] <= 1'b1;
				end else begin
					busy_a_q[alloc_idx] <= 1'b1;
				end
			end
			if (cmd.inc) begin
				if (cls) begin
					val_b_q[gate_q] <= 1'b1;
				end else begin
					val_a_q[gate_q] <= 1'b1;
				end
			end
			if (cmd.sum_step) begin
				pend_q <= issue_sum;
				if (issue_sum) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (!pend_q) begin
					cnt_q <= '0;
				end
			end
			if (cmd.max_step) begin
				pend_q <= issue_max;
				if (issue_max) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (cmd.finish) begin
				busy_a_q <= '0;
				busy_b_q <= '0;
				val_a_q  <= '0;
				val_b_q  <= '0;
				last_a_q <= '0;
				last_b_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q        <= in_command;
			arrive_q     <= in_arrive;
			depart_q     <= in_depart;
			sa_q         <= '0;
			sb_q         <= '0;
			best_q       <= '0;
			res_gate_q   <= '0;
			res_served_q <= 1'b0;
			res_err_q    <= 1'b0;
			res_best_q   <= '0;
			res_report_q <= 1'b0;
		end
		if (cmd.check) begin
			res_err_q <= order_err;
		end
		if (cmd.alloc && !none_free) begin
			gate_q       <= alloc_idx;
			res_gate_q   <= lfga_pkg::GATE_NUM_W'(alloc_idx) + lfga_pkg::GATE_NUM_W'(1);
			res_served_q <= 1'b1;
			if (cls) begin
				rel_b_q[alloc_idx] <= depart_q;
			end else begin
				rel_a_q[alloc_idx] <= depart_q;
			end
		end
		if (cmd.sum_step) begin
			pend_addr_q <= cnt_q[GW-1:0];
			if (pend_q) begin
				sa_q <= pre_a;
				sb_q <= pre_b;
			end
		end
		if (cmd.max_step) begin
			za_q <= (cnt_q == '0);
			zb_q <= (cnt_q == n_act);
			if (pend_q && (tsum > best_q)) begin
				best_q <= tsum;
			end
		end
		if (cmd.finish) begin
			res_report_q <= 1'b1;
			res_best_q   <= (best_q > SW'(lfga_pkg::BEST_MAX)) ?
				lfga_pkg::BEST_W'(lfga_pkg::BEST_MAX) : lfga_pkg::BEST_W'(best_q);
		end
		if (cmd.load_out) begin
			out_gate   <= res_gate_q;
			out_served <= res_served_q;
			out_err    <= res_err_q;
			out_best   <= res_best_q;
			out_report <= res_report_q;
		end
	end

	assign status.command   = cmd_q;
	assign status.order_err = order_err;
	assign status.none_free = none_free;
	assign status.sum_done  = !issue_sum && !pend_q;
	assign status.max_done  = !issue_max && !pend_q;
	assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/lowest_free_gate_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-free gate allocator
// Two-class booking allocator over a shared pool of gates with a split report.
// ----------------------------------------------------------------------------
// Steps: a served booking goes through check, allocate and count update, a
//   refused one skips the update, an out-of-order or unused word goes straight
//   to the result; finish makes two linear passes over the use-count RAMs.
// Flow: one word at a time; the next is taken as its result is loaded out.
// Reset: arst_n clears all busy and valid bits, last arrivals, gate_total and
//   the controller at once; departure registers and RAM contents need none.
// ----------------------------------------------------------------------------
module lowest_free_gate_allocator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfga_pkg::GATE_TOTAL_W-1:0] cfg_data,
	lfga_item_if.sink                         item,
	lfga_result_if.source                     result
);

	lfga_pkg::ctrl_cmd_t  cmd;
	lfga_pkg::dp_status_t status;
	logic                 in_ready;

	assign item.ready = in_ready;

	// Controller: one word in flight. It takes a new word while idle, or in the
	// cycle that hands the finished result to the output register, so a waiting
	// result does not block the next booking's work.
	lfga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: booking frees expired gates of the word's class in parallel,
	// picks the lowest free gate below the limit, then bumps that gate's use
	// count in its RAM. Finish turns the counts into prefix sums in place, then
	// walks the splits, pairing class a prefix i with class b prefix n-i.
	lfga_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_command (item.command),
		.in_arrive  (item.arrive_time),
		.in_depart  (item.depart_time),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_gate   (result.gate_index),
		.out_served (result.served),
		.out_err    (result.order_error),
		.out_best   (result.best_total),
		.out_report (result.report_valid)
	);

`ifndef SYNTHESIS
	// a finish report never carries a gate or an order flag
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.report_valid |->
			result.gate_index == '0 && !result.served && !result.order_error)
		else $error("finish report carries booking fields");

	// served exactly when a gate number is given
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.served == (result.gate_index != '0)))
		else $error("served flag disagrees with gate index");

	// a flagged booking is never served
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.order_error |-> !result.served)
		else $error("out-of-order booking was served");

	// an accept is never followed by another accept in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("word accepted on consecutive cycles");
`endif

endmodule
